/* rtl/pdt_pkg.sv */
// pdt_pkg: shared types and constants for the pair dominance table
// used by pdt_ctrl and pair_dominance_table_lru; no dependencies
package pdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TAG_BITS_DEF      = 32;
    localparam int STAMP_BITS        = 32;
    localparam int PORT_TAG_BITS     = 32;

    typedef struct packed {
        logic [PORT_TAG_BITS-1:0] first_tag;
        logic                     first_absent;
        logic [PORT_TAG_BITS-1:0] second_tag;
        logic                     second_absent;
    } request_t;

    typedef struct packed {
        logic first_dominates;
        logic entry_created;
        logic entry_replaced;
    } result_t;

    // handshake from the controller to the output register
    typedef struct packed {
        logic    valid;
        result_t data;
    } res_push_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

/* rtl/pdt_mem.sv */
// pdt_mem: single write port, single read port synchronous entry memory
// registered read data; no package dependencies
module pdt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pdt_ctrl.sv */
// pdt_ctrl: scan sequencer, valid bits and stamp counter of the pair table
// depends on pdt_pkg; drives the read and write ports of pdt_mem
module pdt_ctrl #(
    parameter int TABLE_ENTRIES = pdt_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = pdt_pkg::TAG_BITS_DEF,
    localparam int IDX_BITS     = $clog2(TABLE_ENTRIES),
    localparam int ENTRY_BITS   = 2 * TAG_BITS + pdt_pkg::STAMP_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  pdt_pkg::request_t     req,
    output pdt_pkg::res_push_t    res_push,
    input  logic                  res_ready,
    output logic                  mem_we,
    output logic [IDX_BITS-1:0]   mem_waddr,
    output logic [ENTRY_BITS-1:0] mem_wdata,
    output logic [IDX_BITS-1:0]   mem_raddr,
    input  logic [ENTRY_BITS-1:0] mem_rdata
);

    localparam int SB = pdt_pkg::STAMP_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

    pdt_pkg::state_t        state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [SB-1:0]          stamp_reg, stamp_next;
    logic [IDX_BITS-1:0]    cnt_reg, cnt_next;
    logic [TAG_BITS-1:0]    a_reg, a_next, b_reg, b_next;
    logic                   fwd_hit_reg, fwd_hit_next, rev_hit_reg, rev_hit_next;
    logic                   free_hit_reg, free_hit_next;
    logic [IDX_BITS-1:0]    fwd_idx_reg, fwd_idx_next, rev_idx_reg, rev_idx_next;
    logic [IDX_BITS-1:0]    free_idx_reg, free_idx_next, min_idx_reg, min_idx_next;
    logic [SB-1:0]          min_stamp_reg, min_stamp_next;
    pdt_pkg::result_t       res_reg, res_next;

    logic [TAG_BITS-1:0]    rd_winner, rd_loser;
    logic [SB-1:0]          rd_stamp;
    logic [IDX_BITS-1:0]    wslot;
    logic                   swap_tags;

    assign rd_winner = mem_rdata[ENTRY_BITS-1 -: TAG_BITS];
    assign rd_loser  = mem_rdata[SB +: TAG_BITS];
    assign rd_stamp  = mem_rdata[SB-1:0];

    // slot chosen at write back: forward hit, reverse hit, free, then lru
    assign wslot = fwd_hit_reg  ? fwd_idx_reg  :
                   rev_hit_reg  ? rev_idx_reg  :
                   free_hit_reg ? free_idx_reg : min_idx_reg;
    assign swap_tags = rev_hit_reg && !fwd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdt_pkg::ST_IDLE;
            valid_reg <= '0;
            stamp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        fwd_hit_reg   <= fwd_hit_next;
        rev_hit_reg   <= rev_hit_next;
        free_hit_reg  <= free_hit_next;
        fwd_idx_reg   <= fwd_idx_next;
        rev_idx_reg   <= rev_idx_next;
        free_idx_reg  <= free_idx_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        stamp_next     = stamp_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fwd_hit_next   = fwd_hit_reg;
        rev_hit_next   = rev_hit_reg;
        free_hit_next  = free_hit_reg;
        fwd_idx_next   = fwd_idx_reg;
        rev_idx_next   = rev_idx_reg;
        free_idx_next  = free_idx_reg;
        min_idx_next   = min_idx_reg;
        min_stamp_next = min_stamp_reg;
        res_next       = res_reg;
        req_stall      = 1'b1;
        res_push.valid = 1'b0;
        res_push.data  = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = wslot;
        mem_wdata      = {swap_tags ? b_reg : a_reg, swap_tags ? a_reg : b_reg, stamp_reg};
        mem_raddr      = '0;

        case (state_reg)
            pdt_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    a_next        = TAG_BITS'(req.first_tag);
                    b_next        = TAG_BITS'(req.second_tag);
                    cnt_next      = '0;
                    fwd_hit_next  = 1'b0;
                    rev_hit_next  = 1'b0;
                    free_hit_next = 1'b0;
                    res_next      = '0;
                    if (req.first_absent)
                    begin
                        state_next = pdt_pkg::ST_DONE;
                    end
                    else if (req.second_absent)
                    begin
                        res_next.first_dominates = 1'b1;
                        state_next = pdt_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pdt_pkg::ST_SCAN;
                    end
                end
            end

            pdt_pkg::ST_SCAN:
            begin
                // entry cnt_reg is on the read port, fetch the following one
                mem_raddr = cnt_reg + 1'b1;
                if (!valid_reg[cnt_reg])
                begin
                    if (!free_hit_reg)
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = cnt_reg;
                    end
                end
                else
                begin
                    if (!fwd_hit_reg && rd_winner == a_reg && rd_loser == b_reg)
                    begin
                        fwd_hit_next = 1'b1;
                        fwd_idx_next = cnt_reg;
                    end
                    if (!rev_hit_reg && rd_winner == b_reg && rd_loser == a_reg)
                    begin
                        rev_hit_next = 1'b1;
                        rev_idx_next = cnt_reg;
                    end
                    // min only matters when every entry is valid
                    if (cnt_reg == '0 || rd_stamp < min_stamp_reg)
                    begin
                        min_stamp_next = rd_stamp;
                        min_idx_next   = cnt_reg;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = pdt_pkg::ST_WRITE;
                end
            end

            pdt_pkg::ST_WRITE:
            begin
                mem_we            = 1'b1;
                valid_next[wslot] = 1'b1;
                stamp_next        = stamp_reg + 1'b1;
                res_next.first_dominates = fwd_hit_reg || !rev_hit_reg;
                res_next.entry_created   = !fwd_hit_reg && !rev_hit_reg;
                res_next.entry_replaced  = !fwd_hit_reg && !rev_hit_reg && !free_hit_reg;
                state_next = pdt_pkg::ST_DONE;
            end

            pdt_pkg::ST_DONE:
            begin
                res_push.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = pdt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pdt_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdt_pkg::ST_SCAN && cnt_reg != LAST_IDX)
        |=> (state_reg == pdt_pkg::ST_SCAN && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("scan index did not advance");

    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdt_pkg::ST_WRITE) |=> valid_reg[$past(wslot)])
        else $error("written entry not marked valid");

    a_stamp_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pdt_pkg::ST_WRITE) |=> (stamp_reg == $past(stamp_reg)))
        else $error("stamp counter moved outside write back");

    a_replace_create: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push.valid && res_push.data.entry_replaced) |-> res_push.data.entry_created)
        else $error("replacement reported without creation");
`endif

endmodule

/* rtl/pair_dominance_table_lru.sv */
// pair_dominance_table_lru: top level of the pair dominance table
// depends on pdt_pkg, pdt_mem and pdt_ctrl
//
// usage:
//   req channel (req_valid, req_stall, req) carries one query item: two tags
//   with their null flags. rsp channel (rsp_valid, rsp_stall, rsp) returns
//   one result item per query: first_dominates, entry_created,
//   entry_replaced. an item moves when valid is high and stall is low.
// flow:
//   a query with a null tag skips the scan and the write back and goes
//   straight to the done state of the controller.
//   a full query walks the TABLE_ENTRIES entries of the entry memory, one
//   read per cycle through its single read port, then writes back once.
//   a new item is taken only once the controller has handed the last
//   result to the output register and returned to idle.
// stall: the result sits in an output register; the controller finishes
//   the next item meanwhile and waits in its done state until that
//   register frees up.
// reset: all entries become invalid and the stamp counter clears at once;
//   no clearing pass, the first item may be taken right after reset.
module pair_dominance_table_lru #(
    parameter int TABLE_ENTRIES = pdt_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = pdt_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pdt_pkg::request_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pdt_pkg::result_t  rsp
);

    localparam int IDX_BITS   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_BITS = 2 * TAG_BITS + pdt_pkg::STAMP_BITS;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr, mem_raddr;
    logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata;
    pdt_pkg::res_push_t    res_push;
    logic                  res_ready;
    logic                  rsp_valid_reg, rsp_valid_next;
    pdt_pkg::result_t      rsp_reg, rsp_next;

    pdt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAG_BITS      (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_push  (res_push),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pdt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_push.valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_push.data;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
